/* design/esc_pkg.sv */
// ----------------------------------------------------------------------------
// esc_pkg: shared types and constants of the eviction selection checker
// Item layouts, status codes, register indexes and default sizes.
// ----------------------------------------------------------------------------
package esc_pkg;

  localparam int TIME_W      = 64;
  localparam int BYTES_W     = 64;
  localparam int IDX_W       = 12;
  localparam int DISK_W      = 4;
  localparam int DISK_SLOTS  = 16;
  localparam int COUNT_W     = 11;
  localparam int PRESS_W     = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 64;
  localparam int QUEUE_DEPTH = 4;

  localparam int NUM_DISKS_DEF      = 16;
  localparam int MAX_CANDIDATES_DEF = 1024;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BATCH_LIMIT       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CANDIDATE_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROTECTION_PERIOD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESSURED_DISKS   = 2'd3;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_BATCH = 3'd1,
    ST_RANGE = 3'd2,
    ST_DUP   = 3'd3,
    ST_PROT  = 3'd4,
    ST_NOREL = 3'd5
  } status_t;

  typedef struct packed {
    logic                req_type;
    logic [IDX_W-1:0]    cand_index;
    logic [TIME_W-1:0]   ready_at;
    logic [TIME_W-1:0]   last_access_at;
    logic [TIME_W-1:0]   now_time;
    logic [DISK_W-1:0]   disk;
    logic [BYTES_W-1:0]  footprint;
    logic                first_entry;
    logic                last_entry;
    logic                has_entry;
  } in_item_t;

  typedef struct packed {
    status_t             status;
    logic [DISK_W-1:0]   disk_out;
    logic [BYTES_W-1:0]  released_bytes;
    logic                entry_valid;
    logic                last;
  } out_item_t;

  // classified item passed from front to back
  typedef struct packed {
    logic                is_end;
    logic                first;
    logic                last;
    logic                adds;
    logic                in_range;
    logic                prot;
    logic [IDX_W-1:0]    idx;
    logic [DISK_W-1:0]   disk;
    logic [BYTES_W-1:0]  footprint;
  } q_item_t;

endpackage

/* design/esc_in_if.sv */
// ----------------------------------------------------------------------------
// esc_in_if: input item channel
// Valid/ready channel carrying one footprint or end item.
// ----------------------------------------------------------------------------
interface esc_in_if;
  import esc_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

/* design/esc_out_if.sv */
// ----------------------------------------------------------------------------
// esc_out_if: result item channel
// Valid/ready channel carrying one check result.
// ----------------------------------------------------------------------------
interface esc_out_if;
  import esc_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

/* design/esc_ram.sv */
// ----------------------------------------------------------------------------
// esc_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module esc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* design/esc_front.sv */
// ----------------------------------------------------------------------------
// esc_front: accept and classify stage
// Takes input items, works out range, protection and pressured release.
// ----------------------------------------------------------------------------
module esc_front #(
  parameter int NUM_DISKS      = esc_pkg::NUM_DISKS_DEF,
  parameter int MAX_CANDIDATES = esc_pkg::MAX_CANDIDATES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  esc_in_if.sink                        in_ch,
  input  logic [esc_pkg::COUNT_W-1:0]   candidate_count,
  input  logic [esc_pkg::TIME_W-1:0]    protection_period,
  input  logic [esc_pkg::PRESS_W-1:0]   pressured_disks,
  output logic                          push_valid,
  input  logic                          push_ready,
  output esc_pkg::q_item_t              push_item
);
  import esc_pkg::*;

  localparam int LIM_W = IDX_W + 1;
  localparam logic [LIM_W-1:0] MAX_LIM = LIM_W'(MAX_CANDIDATES);

  logic                s1_v_r, s1_v_nxt;
  logic                req_type_r, first_r, last_r, adds_r;
  logic [IDX_W-1:0]    idx_r;
  logic [DISK_W-1:0]   disk_r;
  logic [BYTES_W-1:0]  fp_r;
  logic [TIME_W-1:0]   now_r, eff_r;

  logic                accept;
  logic [TIME_W-1:0]   eff_in;
  logic                adds_in;
  logic [LIM_W-1:0]    cc_ext, limit;
  logic [TIME_W:0]     age;
  logic                in_range, prot;

  assign in_ch.ready = !s1_v_r || push_ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // newest of ready and last access
  assign eff_in = (in_ch.item.ready_at > in_ch.item.last_access_at) ?
                  in_ch.item.ready_at : in_ch.item.last_access_at;

  assign adds_in = in_ch.item.has_entry && (in_ch.item.footprint != '0) &&
                   (32'(in_ch.item.disk) < NUM_DISKS) &&
                   pressured_disks[in_ch.item.disk];

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (accept) begin
      s1_v_nxt = 1'b1;
    end else if (push_ready) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
    if (accept) begin
      req_type_r <= in_ch.item.req_type;
      first_r    <= in_ch.item.first_entry;
      last_r     <= in_ch.item.last_entry;
      adds_r     <= adds_in;
      idx_r      <= in_ch.item.cand_index;
      disk_r     <= in_ch.item.disk;
      fp_r       <= in_ch.item.footprint;
      now_r      <= in_ch.item.now_time;
      eff_r      <= eff_in;
    end
  end

  // index limit is the smaller of candidate_count and storage
  assign cc_ext   = LIM_W'(candidate_count);
  assign limit    = (cc_ext < MAX_LIM) ? cc_ext : MAX_LIM;
  assign in_range = {1'b0, idx_r} < limit;

  // borrow means the newest time is in the future
  assign age  = {1'b0, now_r} - {1'b0, eff_r};
  assign prot = age[TIME_W] || (age[TIME_W-1:0] < protection_period);

  assign push_valid = s1_v_r;

  always_comb begin
    push_item.is_end    = req_type_r;
    push_item.first     = first_r;
    push_item.last      = last_r;
    push_item.adds      = adds_r;
    push_item.in_range  = in_range;
    push_item.prot      = prot;
    push_item.idx       = idx_r;
    push_item.disk      = disk_r;
    push_item.footprint = fp_r;
  end

endmodule

/* design/esc_queue.sv */
// ----------------------------------------------------------------------------
// esc_queue: small item queue between front and back
// Flip-flop FIFO with head read at the read pointer.
// ----------------------------------------------------------------------------
module esc_queue #(
  parameter int DEPTH = esc_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  esc_pkg::q_item_t  push_item,
  output logic              pop_valid,
  input  logic              pop,
  output esc_pkg::q_item_t  pop_item
);
  import esc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  q_item_t         slots_r [DEPTH];
  logic [PW-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign push_ready = (cnt_r != FULL_CNT);
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = slots_r[rd_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_nxt  = do_push ? ((wr_r == LAST_PTR) ? '0 : wr_r + 1'b1) : wr_r;
    rd_nxt  = do_pop  ? ((rd_r == LAST_PTR) ? '0 : rd_r + 1'b1) : rd_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      slots_r[wr_r] <= push_item;
    end
  end

endmodule

/* design/esc_back.sv */
// ----------------------------------------------------------------------------
// esc_back: selection state and result sequencer
// Applies classified items to the batch state and emits the verdict.
// ----------------------------------------------------------------------------
module esc_back #(
  parameter int MAX_CANDIDATES = esc_pkg::MAX_CANDIDATES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         head_valid,
  input  esc_pkg::q_item_t             head,
  output logic                         pop,
  input  logic [esc_pkg::COUNT_W-1:0]  batch_limit,
  esc_out_if.source                    out_ch
);
  import esc_pkg::*;

  localparam int AW = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_CANDIDATES - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_RUN,
    S_SEEN,
    S_DECIDE,
    S_WALK
  } state_t;

  state_t                 state_r, state_nxt;
  logic [COUNT_W-1:0]     count_r, count_nxt;
  status_t                err_r, err_nxt;
  logic [DISK_SLOTS-1:0]  touched_r, touched_nxt;
  logic                   open_r, open_nxt;
  logic                   contrib_r, contrib_nxt;
  logic [DISK_W-1:0]      walk_r, walk_nxt;
  logic [AW-1:0]          clr_r, clr_nxt;
  logic                   out_v_r, out_v_nxt;
  out_item_t              out_item_r, out_item_nxt;

  logic [BYTES_W-1:0]     totals_r [DISK_SLOTS];
  logic [DISK_W-1:0]      tot_addr;
  logic [BYTES_W-1:0]     tot_rd;
  logic [BYTES_W:0]       sum;
  logic [BYTES_W-1:0]     sat_sum;
  logic                   tot_we;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [0:0]             ram_wdata;
  logic [0:0]             seen_rd;

  logic                   out_free;
  logic                   do_entry;
  status_t                err_c;
  logic                   contrib_c;
  logic                   higher_none;

  esc_ram #(
    .WIDTH (1),
    .DEPTH (MAX_CANDIDATES)
  ) u_seen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (head.idx[AW-1:0]),
    .rdata (seen_rd)
  );

  // untouched disks read as zero
  assign tot_addr = (state_r == S_WALK) ? walk_r : head.disk;
  assign tot_rd   = touched_r[tot_addr] ? totals_r[tot_addr] : '0;
  assign sum      = {1'b0, tot_rd} + {1'b0, head.footprint};
  assign sat_sum  = sum[BYTES_W] ? '1 : sum[BYTES_W-1:0];

  assign out_free    = !out_v_r || out_ch.ready;
  assign higher_none = ((touched_r >> walk_r) >> 1) == '0;

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    err_nxt      = err_r;
    touched_nxt  = touched_r;
    open_nxt     = open_r;
    contrib_nxt  = contrib_r;
    walk_nxt     = walk_r;
    clr_nxt      = clr_r;
    out_v_nxt    = out_v_r;
    out_item_nxt = out_item_r;
    tot_we       = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = clr_r;
    ram_wdata    = 1'b0;
    pop          = 1'b0;
    do_entry     = 1'b0;
    err_c        = err_r;
    contrib_c    = contrib_r;

    if (out_v_r && out_ch.ready) begin
      out_v_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        ram_we      = 1'b1;
        count_nxt   = '0;
        err_nxt     = ST_OK;
        touched_nxt = '0;
        open_nxt    = 1'b0;
        contrib_nxt = 1'b0;
        walk_nxt    = '0;
        clr_nxt     = clr_r + 1'b1;
        if (clr_r == LAST_ADDR) begin
          clr_nxt   = '0;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (head_valid) begin
          if (head.is_end || head.first) begin
            // close any open candidate first
            if (open_r && !contrib_r && err_r == ST_OK) begin
              err_nxt = ST_NOREL;
            end
            contrib_nxt = 1'b0;
            if (head.is_end) begin
              open_nxt  = 1'b0;
              pop       = 1'b1;
              state_nxt = S_DECIDE;
            end else begin
              open_nxt  = 1'b1;
              if (count_r != '1) begin
                count_nxt = count_r + 1'b1;
              end
              state_nxt = S_SEEN;
            end
          end else if (!open_r) begin
            pop = 1'b1;
          end else begin
            pop      = 1'b1;
            do_entry = 1'b1;
          end
        end
      end
      S_SEEN: begin
        if (err_r == ST_OK) begin
          if (!head.in_range) begin
            err_c = ST_RANGE;
          end else if (seen_rd[0]) begin
            err_c = ST_DUP;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = head.idx[AW-1:0];
            ram_wdata = 1'b1;
            if (head.prot) begin
              err_c = ST_PROT;
            end
          end
        end
        pop       = 1'b1;
        do_entry  = 1'b1;
        state_nxt = S_RUN;
      end
      S_DECIDE: begin
        if (out_free) begin
          out_item_nxt.disk_out       = '0;
          out_item_nxt.released_bytes = '0;
          out_item_nxt.entry_valid    = 1'b0;
          out_item_nxt.last           = 1'b1;
          if (batch_limit == '0 || count_r > batch_limit) begin
            out_item_nxt.status = ST_BATCH;
            out_v_nxt           = 1'b1;
            state_nxt           = S_CLEAR;
          end else if (err_r != ST_OK) begin
            out_item_nxt.status = err_r;
            out_v_nxt           = 1'b1;
            state_nxt           = S_CLEAR;
          end else if (touched_r == '0) begin
            out_item_nxt.status = ST_OK;
            out_v_nxt           = 1'b1;
            state_nxt           = S_CLEAR;
          end else begin
            out_item_nxt = out_item_r;
            walk_nxt     = '0;
            state_nxt    = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (!touched_r[walk_r]) begin
          walk_nxt = walk_r + 1'b1;
        end else if (out_free) begin
          out_item_nxt.status         = ST_OK;
          out_item_nxt.disk_out       = walk_r;
          out_item_nxt.released_bytes = tot_rd;
          out_item_nxt.entry_valid    = 1'b1;
          out_item_nxt.last           = higher_none;
          out_v_nxt                   = 1'b1;
          walk_nxt                    = walk_r + 1'b1;
          if (higher_none) begin
            state_nxt = S_CLEAR;
          end
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase

    // footprint add and candidate close for an entry
    if (do_entry) begin
      if (err_c == ST_OK && head.adds) begin
        contrib_c                = 1'b1;
        tot_we                   = 1'b1;
        touched_nxt[head.disk]   = 1'b1;
      end
      if (head.last) begin
        if (!contrib_c && err_c == ST_OK) begin
          err_c = ST_NOREL;
        end
        open_nxt  = 1'b0;
        contrib_c = 1'b0;
      end
      err_nxt     = err_c;
      contrib_nxt = contrib_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      count_r    <= '0;
      err_r      <= ST_OK;
      touched_r  <= '0;
      open_r     <= 1'b0;
      contrib_r  <= 1'b0;
      walk_r     <= '0;
      clr_r      <= '0;
      out_v_r    <= 1'b0;
      out_item_r <= out_item_nxt;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      err_r      <= err_nxt;
      touched_r  <= touched_nxt;
      open_r     <= open_nxt;
      contrib_r  <= contrib_nxt;
      walk_r     <= walk_nxt;
      clr_r      <= clr_nxt;
      out_v_r    <= out_v_nxt;
      out_item_r <= out_item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tot_we) begin
      totals_r[head.disk] <= sat_sum;
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.item  = out_item_r;

endmodule

/* design/eviction_selection_checker.sv */
// ----------------------------------------------------------------------------
// eviction_selection_checker: checks a proposed eviction batch
// Top level: configuration registers, front, queue and back.
// ----------------------------------------------------------------------------
// usage
//   in_ch takes footprint items and end items (valid/ready, accepted when
//   both are high). first_entry/last_entry frame one selected candidate.
//   out_ch gives results: one error, or one ok item per touched disk in
//   ascending disk order, or one empty ok item; last marks the final one.
//   cfg_we/cfg_index/cfg_wdata write batch_limit, candidate_count, protection_period
//   and pressured_disks; the user must write them only while the block is idle (not enforced).
// sequencing
//   an accepted item is registered in the front, then written into the queue,
//   whose head the back reads; the back handles a first entry in S_RUN (seen-map
//   read) and then S_SEEN (check and write), and any other entry in S_RUN alone
//   an end item passes S_RUN and S_DECIDE, then, if disks were touched, S_WALK
//   steps over the 16 disk totals, one result per touched disk
//   after every end item, and after reset, a clearing pass (S_CLEAR) over all
//   MAX_CANDIDATES entries wipes the seen map; the queue still fills
// stalls
//   a held result sits in the output register; the back waits on it while
//   the front keeps taking items until the queue is full
// ----------------------------------------------------------------------------
module eviction_selection_checker #(
  parameter int NUM_DISKS      = esc_pkg::NUM_DISKS_DEF,
  parameter int MAX_CANDIDATES = esc_pkg::MAX_CANDIDATES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  esc_in_if.sink                          in_ch,
  esc_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [esc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [esc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import esc_pkg::*;

  // configuration registers
  logic [COUNT_W-1:0]  batch_limit_r;
  logic [COUNT_W-1:0]  candidate_count_r;
  logic [TIME_W-1:0]   protection_period_r;
  logic [PRESS_W-1:0]  pressured_disks_r;

  // front to queue, queue to back
  logic     push_valid, push_ready;
  q_item_t  push_item;
  logic     head_valid, head_pop;
  q_item_t  head_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      batch_limit_r       <= '0;
      candidate_count_r   <= '0;
      protection_period_r <= '0;
      pressured_disks_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BATCH_LIMIT:       batch_limit_r       <= cfg_wdata[COUNT_W-1:0];
        CFG_CANDIDATE_COUNT:   candidate_count_r   <= cfg_wdata[COUNT_W-1:0];
        CFG_PROTECTION_PERIOD: protection_period_r <= cfg_wdata[TIME_W-1:0];
        CFG_PRESSURED_DISKS:   pressured_disks_r   <= cfg_wdata[PRESS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // classify items: range, protection, pressured release
  esc_front #(
    .NUM_DISKS      (NUM_DISKS),
    .MAX_CANDIDATES (MAX_CANDIDATES)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_ch             (in_ch),
    .candidate_count   (candidate_count_r),
    .protection_period (protection_period_r),
    .pressured_disks   (pressured_disks_r),
    .push_valid        (push_valid),
    .push_ready        (push_ready),
    .push_item         (push_item)
  );

  // decouples the front from back stalls
  esc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (head_valid),
    .pop        (head_pop),
    .pop_item   (head_item)
  );

  // batch state, seen map, disk totals and result walk
  esc_back #(
    .MAX_CANDIDATES (MAX_CANDIDATES)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_valid  (head_valid),
    .head        (head_item),
    .pop         (head_pop),
    .batch_limit (batch_limit_r),
    .out_ch      (out_ch)
  );

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for eviction_selection_checker
// Streams framed candidate footprints and end items into the checker and
// predicts every verdict. A scoreboard compares each result field by field
// under several register settings, including the extremes, and with the
// sender and receiver idling at random.
// ----------------------------------------------------------------------------
module testbench;
  import esc_pkg::*;

  localparam int                 WATCHDOG_LIMIT = 20000;
  // longer than the seen-map clearing pass that follows every end item
  localparam int                 SETTLE_CYCLES  = 1200;
  localparam int                 RANDOM_ITEMS   = 62;
  localparam logic [TIME_W-1:0]  TOP_VAL        = {TIME_W{1'b1}};

  // how the protection times of a first entry relate to now and the period
  typedef enum int {
    AGE_OLD,
    AGE_AT_PERIOD,
    AGE_FUTURE,
    AGE_YOUNG,
    AGE_ALL_MAX,
    AGE_ALL_ZERO
  } age_kind_t;

  // --------------------------------------------------------------------------
  // scoreboard: tracks the selection in progress and queues the verdicts
  // --------------------------------------------------------------------------
  class selection_scoreboard;
    logic [COUNT_W-1:0] batch_limit = '0;
    logic [COUNT_W-1:0] cand_count  = '0;
    logic [TIME_W-1:0]  prot_period = '0;
    logic [PRESS_W-1:0] pressured   = '0;

    logic [BYTES_W-1:0] totals [DISK_SLOTS];
    logic [PRESS_W-1:0] touched;
    bit                 seen [MAX_CANDIDATES_DEF];
    logic [COUNT_W-1:0] sel_count;
    status_t            first_err;
    bit                 contributes;
    bit                 cand_open;

    out_item_t          expected_verdicts [$];
    int                 fails = 0;

    function new();
      clear_selection();
    endfunction

    function void clear_selection();
      foreach (totals[d]) totals[d] = '0;
      foreach (seen[i]) seen[i] = 1'b0;
      touched     = '0;
      sel_count   = '0;
      first_err   = ST_OK;
      contributes = 1'b0;
      cand_open   = 1'b0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_BATCH_LIMIT:       batch_limit = val[COUNT_W-1:0];
        CFG_CANDIDATE_COUNT:   cand_count  = val[COUNT_W-1:0];
        CFG_PROTECTION_PERIOD: prot_period = val[TIME_W-1:0];
        CFG_PRESSURED_DISKS:   pressured   = val[PRESS_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_error(status_t code);
      if (first_err == ST_OK) first_err = code;
    endfunction

    function void close_cand();
      if (cand_open && !contributes) note_error(ST_NOREL);
      cand_open   = 1'b0;
      contributes = 1'b0;
    endfunction

    function bit too_young(logic [TIME_W-1:0] rdy, logic [TIME_W-1:0] acc,
                           logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] eff;
      eff = (rdy > acc) ? rdy : acc;
      return (eff > now) || ((now - eff) < prot_period);
    endfunction

    function void open_cand(in_item_t it);
      int lim;
      lim = (cand_count < MAX_CANDIDATES_DEF) ? int'(cand_count) : MAX_CANDIDATES_DEF;
      close_cand();
      if (sel_count != {COUNT_W{1'b1}}) sel_count++;
      cand_open   = 1'b1;
      contributes = 1'b0;
      if (first_err != ST_OK) return;
      if (int'(it.cand_index) >= lim) begin
        note_error(ST_RANGE);
        return;
      end
      if (seen[it.cand_index]) begin
        note_error(ST_DUP);
        return;
      end
      seen[it.cand_index] = 1'b1;
      if (too_young(it.ready_at, it.last_access_at, it.now_time)) note_error(ST_PROT);
    endfunction

    function void add_bytes(logic [DISK_W-1:0] dsk, logic [BYTES_W-1:0] bytes);
      logic [BYTES_W-1:0] room;
      if (bytes == '0 || !pressured[dsk]) return;
      contributes   = 1'b1;
      room          = {BYTES_W{1'b1}} - totals[dsk];
      totals[dsk]   = totals[dsk] + ((bytes < room) ? bytes : room);
      touched[dsk]  = 1'b1;
    endfunction

    // works out the verdicts caused by one accepted item
    function void predict_item(in_item_t it);
      out_item_t v;
      if (!it.req_type) begin
        if (it.first_entry) open_cand(it);
        else if (!cand_open) return;
        if (first_err == ST_OK && it.has_entry) add_bytes(it.disk, it.footprint);
        if (it.last_entry) close_cand();
        return;
      end
      close_cand();
      v      = '0;
      v.last = 1'b1;
      if (batch_limit == '0 || sel_count > batch_limit) begin
        v.status = ST_BATCH;
        expected_verdicts.push_back(v);
      end else if (first_err != ST_OK) begin
        v.status = first_err;
        expected_verdicts.push_back(v);
      end else if (touched == '0) begin
        v.status = ST_OK;
        expected_verdicts.push_back(v);
      end else begin
        for (int d = 0; d < DISK_SLOTS; d++) begin
          if (touched[d]) begin
            v.status         = ST_OK;
            v.disk_out       = d[DISK_W-1:0];
            v.released_bytes = totals[d];
            v.entry_valid    = 1'b1;
            v.last           = ((touched >> (d + 1)) == '0);
            expected_verdicts.push_back(v);
          end
        end
      end
      clear_selection();
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_verdicts.size() == 0) begin
        $error("unexpected result: status %0d disk_out %0d released_bytes %0h",
               got.status, got.disk_out, got.released_bytes);
        fails++;
        return;
      end
      want = expected_verdicts.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        fails++;
      end
      if (got.disk_out !== want.disk_out) begin
        $error("disk_out: expected %0d, got %0d", want.disk_out, got.disk_out);
        fails++;
      end
      if (got.released_bytes !== want.released_bytes) begin
        $error("released_bytes: expected %0h, got %0h",
               want.released_bytes, got.released_bytes);
        fails++;
      end
      if (got.entry_valid !== want.entry_valid) begin
        $error("entry_valid: expected %0b, got %0b", want.entry_valid, got.entry_valid);
        fails++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        fails++;
      end
    endfunction

    function int pending();
      return expected_verdicts.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset, block
  // --------------------------------------------------------------------------
  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  esc_in_if  in_ch ();
  esc_out_if out_ch ();

  selection_scoreboard sb = new();

  int in_idle_pct   = 0;
  int out_stall_pct = 0;
  int items_sent    = 0;
  int quiet_cycles  = 0;

  eviction_selection_checker uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver: ready drawn fresh every cycle from the current stall rate
  always @(posedge clk) begin
    out_ch.ready <= (out_stall_pct == 0) || ($urandom_range(99) >= out_stall_pct);
  end

  // monitor: every handshake feeds the scoreboard; the watchdog trips when
  // nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) sb.predict_item(in_ch.item);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) sb.check_result(out_ch.item);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // value helpers
  // --------------------------------------------------------------------------
  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // mostly small or near the top, so that totals saturate now and then
  function automatic logic [BYTES_W-1:0] rand_bytes();
    logic [BYTES_W-1:0] b;
    case ($urandom_range(3))
      0:       b = BYTES_W'($urandom_range(1000, 1));
      1:       b = rand64();
      2:       b = TOP_VAL - BYTES_W'($urandom_range(1000));
      default: b = TOP_VAL;
    endcase
    return (b == '0) ? 64'd1 : b;
  endfunction

  // a disk whose pressure bit matches want, if there is one
  function automatic logic [DISK_W-1:0] pick_disk(bit want);
    logic [DISK_W-1:0] d;
    d = DISK_W'($urandom_range(DISK_SLOTS - 1));
    for (int t = 0; t < 64; t++) begin
      d = DISK_W'($urandom_range(DISK_SLOTS - 1));
      if (sb.pressured[d] == want) return d;
    end
    return d;
  endfunction

  // protection times of the requested kind against the current period
  function automatic void make_times(age_kind_t kind, output logic [TIME_W-1:0] rdy,
                                     output logic [TIME_W-1:0] acc,
                                     output logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] p;
    logic [TIME_W-1:0] span;
    logic [TIME_W-1:0] age;
    logic [TIME_W-1:0] eff;
    logic [TIME_W-1:0] other;
    p = sb.prot_period;
    if (kind == AGE_YOUNG && p == '0) kind = AGE_FUTURE;
    case (kind)
      AGE_ALL_MAX: begin
        rdy = TOP_VAL;
        acc = TOP_VAL;
        now = TOP_VAL;
        return;
      end
      AGE_ALL_ZERO: begin
        rdy = '0;
        acc = '0;
        now = '0;
        return;
      end
      AGE_FUTURE: begin
        now = rand64() % TOP_VAL;
        eff = now + 64'd1 + (rand64() % (TOP_VAL - now));
      end
      AGE_YOUNG: begin
        age  = rand64() % p;
        span = TOP_VAL - age;
        now  = age + ((span == TOP_VAL) ? rand64() : rand64() % (span + 64'd1));
        eff  = now - age;
      end
      default: begin
        // aged at least the period; exactly the period at the boundary
        span = TOP_VAL - p;
        now  = p + ((span == TOP_VAL) ? rand64() : rand64() % (span + 64'd1));
        span = now - p;
        age  = (kind == AGE_AT_PERIOD) ? 64'd0 :
               ((span == TOP_VAL) ? rand64() : rand64() % (span + 64'd1));
        eff  = now - p - age;
      end
    endcase
    other = (eff == TOP_VAL) ? rand64() : rand64() % (eff + 64'd1);
    if ($urandom_range(1)) begin
      rdy = eff;
      acc = other;
    end else begin
      rdy = other;
      acc = eff;
    end
  endfunction

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------
  task automatic send_item(in_item_t it, bit counted);
    while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.item  <= it;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (counted) items_sent++;
  endtask

  task automatic send_entry(bit first, bit last, bit has, logic [IDX_W-1:0] idx,
                            logic [DISK_W-1:0] dsk, logic [BYTES_W-1:0] bytes,
                            age_kind_t kind, bit counted = 1'b1);
    in_item_t          it;
    logic [TIME_W-1:0] rdy;
    logic [TIME_W-1:0] acc;
    logic [TIME_W-1:0] now;
    make_times(kind, rdy, acc, now);
    it                = '0;
    it.req_type       = 1'b0;
    it.cand_index     = idx;
    it.ready_at       = rdy;
    it.last_access_at = acc;
    it.now_time       = now;
    it.disk           = dsk;
    it.footprint      = bytes;
    it.first_entry    = first;
    it.last_entry     = last;
    it.has_entry      = has;
    send_item(it, counted);
  endtask

  // end item: every other field is don't-care, so it carries noise
  task automatic send_end();
    in_item_t it;
    it.req_type       = 1'b1;
    it.cand_index     = IDX_W'($urandom_range(4095));
    it.ready_at       = rand64();
    it.last_access_at = rand64();
    it.now_time       = rand64();
    it.disk           = DISK_W'($urandom_range(DISK_SLOTS - 1));
    it.footprint      = rand64();
    it.first_entry    = 1'($urandom_range(1));
    it.last_entry     = 1'($urandom_range(1));
    it.has_entry      = 1'($urandom_range(1));
    send_item(it, 1'b1);
  endtask

  // one candidate: the first entry releases bytes on a pressured disk when
  // asked to, later entries are free-form; no entries means has_entry low
  task automatic send_candidate(logic [IDX_W-1:0] idx, age_kind_t kind, int n_ent,
                                bit frees, bit close_it);
    logic [DISK_W-1:0]  dsk;
    logic [BYTES_W-1:0] bytes;
    if (n_ent == 0) begin
      send_entry(1'b1, close_it, 1'b0, idx, DISK_W'($urandom_range(DISK_SLOTS - 1)),
                 rand64(), kind);
      return;
    end
    for (int e = 0; e < n_ent; e++) begin
      if (frees && e == 0) begin
        dsk   = pick_disk(1'b1);
        bytes = rand_bytes();
      end else if (frees) begin
        dsk   = DISK_W'($urandom_range(DISK_SLOTS - 1));
        bytes = $urandom_range(3) ? rand_bytes() : '0;
      end else begin
        dsk   = pick_disk(1'b0);
        bytes = sb.pressured[dsk] ? '0 : ($urandom_range(1) ? rand_bytes() : '0);
      end
      send_entry(e == 0, close_it && (e == n_ent - 1), 1'b1, idx, dsk, bytes, kind);
    end
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic configure(int bl, int cc, logic [TIME_W-1:0] period,
                           logic [PRESS_W-1:0] press);
    put_reg(CFG_BATCH_LIMIT, CFG_DATA_W'(bl));
    put_reg(CFG_CANDIDATE_COUNT, CFG_DATA_W'(cc));
    put_reg(CFG_PROTECTION_PERIOD, period);
    put_reg(CFG_PRESSURED_DISKS, CFG_DATA_W'(press));
    cfg_we <= 1'b0;
  endtask

  // wait for every verdict, then let the clearing pass run out
  task automatic settle_block();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one well-formed selection with occasional faults and framing noise
  task automatic random_selection();
    int                lim;
    int                cap;
    int                ncand;
    int                roll;
    int                n_ent;
    bit                open_now;
    bit                frees;
    bit                close_it;
    age_kind_t         kind;
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  picked [$];
    bit                taken [int];
    lim = (sb.cand_count < MAX_CANDIDATES_DEF) ? int'(sb.cand_count) : MAX_CANDIDATES_DEF;
    cap = (sb.batch_limit == '0) ? 3 : ((sb.batch_limit < 6) ? int'(sb.batch_limit) : 6);
    roll = $urandom_range(99);
    if (roll < 5) ncand = 0;
    else if (roll < 12 && sb.batch_limit <= 16) ncand = int'(sb.batch_limit) + 1;
    else ncand = $urandom_range(cap, 1);
    open_now = 1'b0;
    for (int c = 0; c < ncand; c++) begin
      // entry without a first flag: part of the open candidate, else dropped
      if ($urandom_range(99) < 4) begin
        send_entry(1'b0, 1'b0, 1'b1, IDX_W'($urandom_range(4095)),
                   DISK_W'($urandom_range(DISK_SLOTS - 1)), rand_bytes(), AGE_OLD,
                   open_now);
      end
      kind    = ($urandom_range(9) == 0) ? AGE_AT_PERIOD : AGE_OLD;
      frees   = 1'b1;
      idx     = IDX_W'($urandom_range(4095));
      if (lim > 0) begin
        for (int t = 0; t < 8; t++) begin
          idx = IDX_W'($urandom_range(lim - 1));
          if (!taken.exists(idx)) break;
        end
      end
      roll = $urandom_range(99);
      if (roll < 3 && lim < 4096) idx = IDX_W'($urandom_range(4095, lim));
      else if (roll < 6 && picked.size() > 0) idx = picked[$urandom_range(picked.size() - 1)];
      else if (roll < 9) kind = $urandom_range(1) ? AGE_YOUNG : AGE_FUTURE;
      else if (roll < 12) frees = 1'b0;
      picked.push_back(idx);
      taken[idx] = 1'b1;
      n_ent    = frees ? $urandom_range(3, 1) : $urandom_range(2, 0);
      close_it = ($urandom_range(99) >= 5);
      send_candidate(idx, kind, n_ent, frees, close_it);
      open_now = !close_it;
    end
    if ($urandom_range(99) < 4) begin
      send_entry(1'b0, 1'($urandom_range(1)), 1'b1, IDX_W'($urandom_range(4095)),
                 DISK_W'($urandom_range(DISK_SLOTS - 1)), rand_bytes(), AGE_OLD, open_now);
    end
    send_end();
  endtask

  task automatic random_phase(int idle_in, int stall_out);
    int start;
    in_idle_pct   = idle_in;
    out_stall_pct = stall_out;
    start         = items_sent;
    while (items_sent - start < RANDOM_ITEMS) random_selection();
    settle_block();
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= '0;
    cfg_wdata   <= '0;
    in_ch.valid <= 1'b0;
    in_ch.item  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: pressured disks 0, 1 and 4 to 7
    configure(3, 8, 64'd100, 16'h00F3);
    // empty selection gives one ok item with no entry
    send_end();
    // dropped entry, then sums that saturate on disk 0, a zero footprint on a
    // pressured disk, and a candidate aged exactly the period left unclosed
    send_entry(1'b0, 1'b0, 1'b1, 12'd5, 4'd0, 64'd9, AGE_OLD, 1'b0);
    send_entry(1'b1, 1'b0, 1'b1, 12'd0, 4'd0, TOP_VAL, AGE_OLD);
    send_entry(1'b0, 1'b0, 1'b1, 12'd0, 4'd0, TOP_VAL, AGE_OLD);
    send_entry(1'b0, 1'b0, 1'b1, 12'd0, 4'd1, 64'd0, AGE_OLD);
    send_entry(1'b0, 1'b1, 1'b1, 12'd0, 4'd7, 64'd1, AGE_OLD);
    send_entry(1'b1, 1'b0, 1'b1, 12'd7, 4'd4, rand_bytes(), AGE_AT_PERIOD);
    send_end();
    // index equal to the candidate count
    send_entry(1'b1, 1'b1, 1'b1, 12'd8, 4'd0, 64'd5, AGE_OLD);
    send_entry(1'b1, 1'b1, 1'b1, 12'd1, 4'd2, 64'd5, AGE_OLD);
    send_end();
    // same candidate twice
    send_entry(1'b1, 1'b1, 1'b1, 12'd2, 4'd5, rand_bytes(), AGE_OLD);
    send_entry(1'b1, 1'b1, 1'b1, 12'd2, 4'd5, rand_bytes(), AGE_OLD);
    send_end();
    // protected: times in the future, then younger than the period
    send_entry(1'b1, 1'b1, 1'b1, 12'd3, 4'd6, rand_bytes(), AGE_FUTURE);
    send_end();
    send_entry(1'b1, 1'b1, 1'b1, 12'd4, 4'd6, rand_bytes(), AGE_YOUNG);
    send_end();
    // candidate without any footprint releases nothing
    send_entry(1'b1, 1'b1, 1'b0, 12'd5, 4'd0, rand64(), AGE_OLD);
    send_end();
    // over the batch limit wins over an earlier range error
    send_entry(1'b1, 1'b1, 1'b1, 12'd4095, 4'd0, 64'd1, AGE_OLD);
    send_entry(1'b1, 1'b1, 1'b1, 12'd1, 4'd0, 64'd1, AGE_OLD);
    send_entry(1'b1, 1'b1, 1'b1, 12'd2, 4'd0, 64'd1, AGE_OLD);
    send_entry(1'b1, 1'b1, 1'b1, 12'd3, 4'd0, 64'd1, AGE_OLD);
    send_end();
    settle_block();

    // zero batch limit rejects even an empty selection
    configure(0, 0, TOP_VAL, 16'h0000);
    send_end();
    send_entry(1'b1, 1'b1, 1'b1, 12'd0, 4'd3, rand_bytes(), AGE_ALL_MAX);
    send_end();
    settle_block();

    // widest limits: every disk touched, top index, index just past storage
    configure(1024, 1024, 64'd0, 16'hFFFF);
    for (int d = 0; d < DISK_SLOTS; d++) begin
      send_entry(d == 0, d == DISK_SLOTS - 1, 1'b1, 12'd1023, DISK_W'(d), rand_bytes(),
                 AGE_ALL_MAX);
    end
    send_entry(1'b1, 1'b1, 1'b1, 12'd0, 4'd15, TOP_VAL, AGE_ALL_ZERO);
    send_end();
    send_entry(1'b1, 1'b1, 1'b1, 12'd1024, 4'd0, 64'd1, AGE_OLD);
    send_end();
    settle_block();

    // random selections under several settings and idling patterns
    configure(8, 64, {32'd0, $urandom()}, PRESS_W'($urandom_range(16'hFFFF)));
    random_phase(0, 0);
    configure(1024, 1024, TOP_VAL, 16'hFFFF);
    random_phase(82, 0);
    configure(16, 12, 64'd0, 16'h8001);
    random_phase(0, 82);
    configure(5, 1000, rand64(), PRESS_W'($urandom_range(16'hFFFF)));
    random_phase(33, 33);

    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
